// ===== hw/rtl/pbps_pkg.sv =====
// Shared types and constants for the priority beep pattern sequencer.
package pbps_pkg;

  // Widths of timing registers and counters
  localparam int TICK_W  = 12;
  localparam int COUNT_W = 13;

  // Request operation carried by an input word
  typedef enum logic [1:0] {
    MODE_POLL  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // Beep patterns, lower code wins
  typedef enum logic [2:0] {
    PAT_IDLE  = 3'd0,
    PAT_READ  = 3'd1,
    PAT_ONE   = 3'd2,
    PAT_TWO   = 3'd3,
    PAT_FOUR  = 3'd4,
    PAT_ADDR  = 3'd5,
    PAT_ALARM = 3'd6,
    PAT_HOLD  = 3'd7
  } pattern_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_READ_ON   = 3'd0,
    CFG_SHORT_ON  = 3'd1,
    CFG_SHORT_OFF = 3'd2,
    CFG_SINGLE_ON = 3'd3,
    CFG_ALARM_ON  = 3'd4,
    CFG_ALARM_OFF = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [TICK_W-1:0] read_on_ticks;
    logic [TICK_W-1:0] short_on_ticks;
    logic [TICK_W-1:0] short_off_ticks;
    logic [TICK_W-1:0] single_on_ticks;
    logic [TICK_W-1:0] alarm_on_ticks;
    logic [TICK_W-1:0] alarm_off_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t    mode;
    pattern_t pattern;
    logic     tick;
  } in_word_t;

  typedef struct packed {
    logic     buzzer_on;
    pattern_t active_pattern;
  } out_word_t;

  // Reset values of the timing registers
  localparam logic [TICK_W-1:0] READ_ON_RST   = 12'd12;
  localparam logic [TICK_W-1:0] SHORT_ON_RST  = 12'd12;
  localparam logic [TICK_W-1:0] SHORT_OFF_RST = 12'd12;
  localparam logic [TICK_W-1:0] SINGLE_ON_RST = 12'd25;
  localparam logic [TICK_W-1:0] ALARM_ON_RST  = 12'd62;
  localparam logic [TICK_W-1:0] ALARM_OFF_RST = 12'd375;

  // Gap and tail limits
  localparam logic [3:0] GAP_LIMIT       = 4'd12;
  localparam logic [5:0] READ_TAIL_LIMIT = 6'd62;
  localparam logic [6:0] CARD_TAIL_LIMIT = 7'd100;

  // Request groups that a set clears
  localparam logic [6:0] SHORT_GROUP = 7'h1E;
  localparam logic [6:0] ALARM_BIT   = 7'h20;
  localparam logic [6:0] HOLD_BIT    = 7'h40;

  // Repeat count loaded on a set, per pattern
  localparam logic [COUNT_W-1:0] LOAD_COUNTS [7] = '{
    13'd1, 13'd1, 13'd2, 13'd4, 13'd1, 13'd20, 13'd7500
  };

endpackage

// ===== hw/rtl/pbps_cfg_regs.sv =====
// Timing configuration registers of the beep sequencer.
module pbps_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [pbps_pkg::TICK_W-1:0] cfg_data,
  output pbps_pkg::cfg_t            cfg
);
  import pbps_pkg::*;

  // Decode writes by register index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_on_ticks   <= READ_ON_RST;
      cfg.short_on_ticks  <= SHORT_ON_RST;
      cfg.short_off_ticks <= SHORT_OFF_RST;
      cfg.single_on_ticks <= SINGLE_ON_RST;
      cfg.alarm_on_ticks  <= ALARM_ON_RST;
      cfg.alarm_off_ticks <= ALARM_OFF_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_READ_ON:   cfg.read_on_ticks   <= cfg_data;
        CFG_SHORT_ON:  cfg.short_on_ticks  <= cfg_data;
        CFG_SHORT_OFF: cfg.short_off_ticks <= cfg_data;
        CFG_SINGLE_ON: cfg.single_on_ticks <= cfg_data;
        CFG_ALARM_ON:  cfg.alarm_on_ticks  <= cfg_data;
        CFG_ALARM_OFF: cfg.alarm_off_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pbps_prio_pick.sv =====
// Lowest-set-bit pick over the seven request bits.
module pbps_prio_pick (
  input  logic [6:0] request_bits,
  output logic       found,
  output logic [2:0] index
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found = |request_bits;
    index = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (request_bits[i]) begin
        index = 3'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/pbps_seq_core.sv =====
// Request bits, pattern selection and on/off timing of the beep sequencer.
module pbps_seq_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 commit,
  input  pbps_pkg::in_word_t   item,
  input  pbps_pkg::cfg_t       cfg,
  output pbps_pkg::out_word_t  result
);
  import pbps_pkg::*;

  logic [6:0]         request_bits, request_bits_next;
  logic [COUNT_W-1:0] pending_counts [7];
  logic [COUNT_W-1:0] pending_counts_next [7];
  pattern_t           current_pattern, current_pattern_next;
  pattern_t           previous_pattern, previous_pattern_next;
  pattern_t           shown_pattern, shown_pattern_next;
  logic [COUNT_W-1:0] repeats_left, repeats_left_next;
  logic               phase_on, phase_on_next;
  logic [COUNT_W-1:0] phase_ticks, phase_ticks_next;
  logic [3:0]         switch_gap_ticks, switch_gap_ticks_next;
  logic [6:0]         tail_ticks, tail_ticks_next;
  logic [5:0]         read_tail_ticks, read_tail_ticks_next;
  logic               buzzer_latch, buzzer_latch_next;

  logic               pick_found;
  logic [2:0]         pick_index;
  logic [TICK_W-1:0]  on_len;
  logic [TICK_W-1:0]  off_len;
  logic [COUNT_W-1:0] old_ticks;
  logic               run_pattern;
  logic               phases_done;
  logic               drop_en;
  pattern_t           drop_pat;

  pbps_prio_pick u_pick (
    .request_bits (request_bits),
    .found        (pick_found),
    .index        (pick_index)
  );

  // Work out the state after one word
  always_comb begin
    request_bits_next     = request_bits;
    pending_counts_next   = pending_counts;
    current_pattern_next  = current_pattern;
    previous_pattern_next = previous_pattern;
    shown_pattern_next    = shown_pattern;
    repeats_left_next     = repeats_left;
    phase_on_next         = phase_on;
    phase_ticks_next      = phase_ticks;
    switch_gap_ticks_next = switch_gap_ticks;
    tail_ticks_next       = tail_ticks;
    read_tail_ticks_next  = read_tail_ticks;
    buzzer_latch_next     = buzzer_latch;
    on_len      = '0;
    off_len     = '0;
    old_ticks   = '0;
    run_pattern = 1'b1;
    phases_done = 1'b0;
    drop_en     = 1'b0;
    drop_pat    = PAT_IDLE;

    unique case (item.mode)
      MODE_POLL: begin
        // Hold countdown runs on every tick, whatever is active
        if (item.tick && pending_counts_next[6] != '0) begin
          pending_counts_next[6] = pending_counts_next[6] - 1'b1;
        end
        // Save alarm repeats so a preempted alarm resumes
        if (current_pattern == PAT_ALARM) begin
          pending_counts_next[5] = repeats_left;
        end

        // Select the active pattern
        if (!pick_found) begin
          current_pattern_next = PAT_IDLE;
        end else if (pick_index < 3'd5) begin
          current_pattern_next = pattern_t'(pick_index + 3'd1);
          if (pending_counts_next[pick_index] != '0) begin
            repeats_left_next                = pending_counts_next[pick_index];
            pending_counts_next[pick_index]  = '0;
          end
        end else if (pick_index == 3'd5) begin
          if (current_pattern != PAT_ALARM) begin
            repeats_left_next = pending_counts_next[5];
          end
          current_pattern_next = PAT_ALARM;
        end else begin
          current_pattern_next = PAT_HOLD;
        end

        // Force a silent gap after leaving a non-idle pattern
        if (previous_pattern != current_pattern_next && previous_pattern != PAT_IDLE) begin
          buzzer_latch_next = 1'b0;
          if (!item.tick) begin
            run_pattern = 1'b0;
          end else if (switch_gap_ticks < GAP_LIMIT) begin
            switch_gap_ticks_next = switch_gap_ticks + 1'b1;
            run_pattern           = 1'b0;
          end else begin
            switch_gap_ticks_next = '0;
          end
        end

        if (run_pattern) begin
          previous_pattern_next = current_pattern_next;

          // Phase lengths of the selected pattern
          case (current_pattern_next) inside
            PAT_READ:            on_len = cfg.read_on_ticks;
            PAT_ONE:             on_len = cfg.single_on_ticks;
            PAT_TWO, PAT_FOUR: begin
              on_len  = cfg.short_on_ticks;
              off_len = cfg.short_off_ticks;
            end
            PAT_ADDR:            on_len = cfg.short_on_ticks;
            PAT_ALARM: begin
              on_len  = cfg.alarm_on_ticks;
              off_len = cfg.alarm_off_ticks;
            end
            default: ;
          endcase

          // Advance on/off phases for the timed patterns
          if (current_pattern_next != PAT_IDLE && current_pattern_next != PAT_HOLD) begin
            if (shown_pattern_next != current_pattern_next) begin
              phase_ticks_next   = '0;
              phase_on_next      = 1'b1;
              shown_pattern_next = current_pattern_next;
            end
            if (item.tick) begin
              if (repeats_left_next == '0) begin
                phase_ticks_next = '0;
                phases_done      = 1'b1;
              end else begin
                old_ticks        = phase_ticks_next;
                phase_ticks_next = old_ticks + 1'b1;
                if (phase_on_next) begin
                  buzzer_latch_next = 1'b1;
                  if (old_ticks > {1'b0, on_len}) begin
                    phase_on_next    = 1'b0;
                    phase_ticks_next = '0;
                  end
                end else begin
                  buzzer_latch_next = 1'b0;
                  if (old_ticks > {1'b0, off_len}) begin
                    phase_on_next     = 1'b1;
                    phase_ticks_next  = '0;
                    repeats_left_next = repeats_left_next - 1'b1;
                  end
                end
              end
            end
          end

          // Tails and self-clearing
          case (current_pattern_next) inside
            PAT_READ: begin
              if (phases_done) begin
                if (read_tail_ticks < READ_TAIL_LIMIT) begin
                  read_tail_ticks_next = read_tail_ticks + 1'b1;
                end else begin
                  read_tail_ticks_next = '0;
                  drop_en              = 1'b1;
                  drop_pat             = PAT_READ;
                end
              end
            end
            PAT_ONE, PAT_TWO, PAT_FOUR: begin
              if (phases_done) begin
                if (tail_ticks < CARD_TAIL_LIMIT) begin
                  tail_ticks_next = tail_ticks + 1'b1;
                end else begin
                  tail_ticks_next = '0;
                  drop_en         = 1'b1;
                  drop_pat        = current_pattern_next;
                end
              end
            end
            PAT_ADDR, PAT_ALARM: begin
              if (phases_done) begin
                drop_en  = 1'b1;
                drop_pat = current_pattern_next;
              end
            end
            PAT_HOLD: begin
              buzzer_latch_next = 1'b1;
              if (pending_counts_next[6] == '0) begin
                drop_en  = 1'b1;
                drop_pat = PAT_HOLD;
              end
            end
            default: buzzer_latch_next = 1'b0;
          endcase
        end
      end

      MODE_SET: begin
        // Clear the competing group, then mark and load
        if (item.pattern != PAT_IDLE) begin
          case (item.pattern) inside
            PAT_READ, PAT_ONE, PAT_TWO, PAT_FOUR, PAT_ADDR:
              request_bits_next = request_bits_next & ~SHORT_GROUP;
            PAT_ALARM: request_bits_next = request_bits_next & ~HOLD_BIT;
            default:   request_bits_next = request_bits_next & ~ALARM_BIT;
          endcase
          request_bits_next = request_bits_next | (7'b1 << (item.pattern - 3'd1));
          pending_counts_next[item.pattern - 3'd1] = LOAD_COUNTS[item.pattern - 3'd1];
        end
      end

      MODE_CLEAR: begin
        drop_en  = 1'b1;
        drop_pat = item.pattern;
      end

      default: ;
    endcase

    // Drop a request; dropping hold also drops its countdown
    if (drop_en && drop_pat != PAT_IDLE) begin
      request_bits_next = request_bits_next & ~(7'b1 << (drop_pat - 3'd1));
      if (drop_pat == PAT_HOLD) begin
        pending_counts_next[6] = '0;
      end
    end
  end

  assign result.buzzer_on      = buzzer_latch_next;
  assign result.active_pattern = current_pattern_next;

  // Commit state on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      request_bits     <= '0;
      pending_counts   <= '{default: '0};
      current_pattern  <= PAT_IDLE;
      previous_pattern <= PAT_IDLE;
      shown_pattern    <= PAT_IDLE;
      repeats_left     <= '0;
      phase_on         <= 1'b1;
      phase_ticks      <= '0;
      switch_gap_ticks <= '0;
      tail_ticks       <= '0;
      read_tail_ticks  <= '0;
      buzzer_latch     <= 1'b0;
    end else if (commit) begin
      request_bits     <= request_bits_next;
      pending_counts   <= pending_counts_next;
      current_pattern  <= current_pattern_next;
      previous_pattern <= previous_pattern_next;
      shown_pattern    <= shown_pattern_next;
      repeats_left     <= repeats_left_next;
      phase_on         <= phase_on_next;
      phase_ticks      <= phase_ticks_next;
      switch_gap_ticks <= switch_gap_ticks_next;
      tail_ticks       <= tail_ticks_next;
      read_tail_ticks  <= read_tail_ticks_next;
      buzzer_latch     <= buzzer_latch_next;
    end
  end

endmodule

// ===== hw/rtl/priority_beep_pattern_sequencer.sv =====
// Top level of the priority beep pattern sequencer: word registers and handshake.
// Each input word (poll, set request or clear request) yields one result word
// with the buzzer enable and the active pattern. Words pass through an input
// register and a result register, and one word is taken every cycle as long as
// the result side keeps up; all of a word's work is done combinationally between
// those two registers. Timing registers take effect on the next word after the write.
module priority_beep_pattern_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pbps_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pbps_pkg::out_word_t         out_word,
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [pbps_pkg::TICK_W-1:0] cfg_data
);
  import pbps_pkg::*;

  in_word_t  in_reg;
  logic      in_reg_valid;
  logic      advance;
  cfg_t      cfg;
  out_word_t result;

  pbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbps_seq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Process the held word when the result register is free
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  // Idle never drives the buzzer
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.active_pattern == PAT_IDLE |-> !out_word.buzzer_on)
    else $error("buzzer on while no pattern is active");

  // A processed word always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed word did not reach the result register");

  // Input stalls only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_reg_valid)
    else $error("input stalled without a stalled result");

endmodule

// ===== sim/tb.sv =====
// Testbench for the priority beep pattern sequencer: random words checked against a predictor.
module tb;
  import pbps_pkg::*;

  // Fixed timing of the sequencer, in ticks
  localparam int GAP_TICKS       = 12;
  localparam int READ_TAIL_TICKS = 62;
  localparam int CARD_TAIL_TICKS = 100;
  localparam int ALARM_REPEATS   = 20;
  localparam int HOLD_TICKS      = 7500;
  localparam bit [6:0] SHORT_REQS = 7'h1E;
  localparam bit [12:0] REPEAT_LOAD [7] = '{
    13'd1, 13'd1, 13'd2, 13'd4, 13'd1, 13'(ALARM_REPEATS), 13'(HOLD_TICKS)
  };
  // Mode code that the block leaves unused
  localparam bit [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 60;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [TICK_W-1:0] cfg_data = '0;

  bit idling;
  bit choke_req;
  int words_sent;

  priority_beep_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicts the buzzer state and active pattern per word and compares them with what comes out
  class beep_scoreboard;
    bit [11:0] tm_read_on, tm_short_on, tm_short_off;
    bit [11:0] tm_single_on, tm_alarm_on, tm_alarm_off;
    bit [6:0]  req;
    bit [12:0] pend [7];
    pattern_t  cur, prev, shown;
    bit [12:0] reps;
    bit        phase_on;
    bit [12:0] phase_cnt;
    bit [3:0]  gap_cnt;
    bit [6:0]  tail_cnt;
    bit [5:0]  read_tail_cnt;
    bit        buzz;
    out_word_t beeps_due [$];
    int        errors;

    function new();
      tm_read_on   = 12'd12;
      tm_short_on  = 12'd12;
      tm_short_off = 12'd12;
      tm_single_on = 12'd25;
      tm_alarm_on  = 12'd62;
      tm_alarm_off = 12'd375;
      req = '0;
      foreach (pend[i]) pend[i] = '0;
      cur = PAT_IDLE;
      prev = PAT_IDLE;
      shown = PAT_IDLE;
      reps = '0;
      phase_on = 1'b1;
      phase_cnt = '0;
      gap_cnt = '0;
      tail_cnt = '0;
      read_tail_cnt = '0;
      buzz = 1'b0;
      errors = 0;
    endfunction

    function void set_timing(cfg_index_t idx, bit [11:0] v);
      case (idx)
        CFG_READ_ON:   tm_read_on = v;
        CFG_SHORT_ON:  tm_short_on = v;
        CFG_SHORT_OFF: tm_short_off = v;
        CFG_SINGLE_ON: tm_single_on = v;
        CFG_ALARM_ON:  tm_alarm_on = v;
        CFG_ALARM_OFF: tm_alarm_off = v;
        default: ;
      endcase
    endfunction

    function void clear_request(bit [2:0] p);
      if (p == PAT_IDLE) return;
      req[p-1] = 1'b0;
      if (p == PAT_HOLD) pend[PAT_HOLD-1] = '0;
    endfunction

    // Set drops the competing group, then marks and loads its own count
    function void set_request(bit [2:0] p);
      case (p)
        PAT_IDLE:  return;
        PAT_ALARM: req[PAT_HOLD-1] = 1'b0;
        PAT_HOLD:  req[PAT_ALARM-1] = 1'b0;
        default:   req &= ~SHORT_REQS;
      endcase
      req[p-1] = 1'b1;
      pend[p-1] = REPEAT_LOAD[p-1];
    endfunction

    function void pick_pattern(bit tick);
      int i;
      if (tick && pend[PAT_HOLD-1] > 0) pend[PAT_HOLD-1]--;
      // Park the alarm repeats so a preempted alarm resumes
      if (cur == PAT_ALARM) pend[PAT_ALARM-1] = reps;
      i = 0;
      while (i < 7 && !req[i]) i++;
      if (i == 7) begin
        cur = PAT_IDLE;
      end else if (i < 5) begin
        cur = pattern_t'(i + 1);
        if (pend[i] > 0) begin
          reps = pend[i];
          pend[i] = '0;
        end
      end else if (i == 5) begin
        if (cur != PAT_ALARM) reps = pend[PAT_ALARM-1];
        cur = PAT_ALARM;
      end else begin
        cur = PAT_HOLD;
      end
    endfunction

    // Advance the on/off phases; true on a tick once the repeats are used up
    function bit run_phases(bit tick, bit [11:0] on_len, bit [11:0] off_len);
      bit [12:0] old;
      if (shown != cur) begin
        phase_cnt = '0;
        phase_on = 1'b1;
        shown = cur;
      end
      if (!tick) return 1'b0;
      if (reps == 0) begin
        phase_cnt = '0;
        return 1'b1;
      end
      old = phase_cnt;
      phase_cnt = old + 1'b1;
      if (phase_on) begin
        buzz = 1'b1;
        if (old > on_len) begin
          phase_on = 1'b0;
          phase_cnt = '0;
        end
      end else begin
        buzz = 1'b0;
        if (old > off_len) begin
          phase_on = 1'b1;
          phase_cnt = '0;
          reps = reps - 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Count the silent tail after a card beep; true when it runs out
    function bit tail_done(bit read_tail);
      if (read_tail) begin
        if (read_tail_cnt < READ_TAIL_TICKS) begin
          read_tail_cnt++;
          return 1'b0;
        end
        read_tail_cnt = '0;
        return 1'b1;
      end
      if (tail_cnt < CARD_TAIL_TICKS) begin
        tail_cnt++;
        return 1'b0;
      end
      tail_cnt = '0;
      return 1'b1;
    endfunction

    function void poll(bit tick);
      pick_pattern(tick);
      // Hold the buzzer off through the switch gap
      if (prev != cur && prev != PAT_IDLE) begin
        buzz = 1'b0;
        if (!tick) return;
        if (gap_cnt < GAP_TICKS) begin
          gap_cnt++;
          return;
        end
        gap_cnt = '0;
      end
      prev = cur;
      case (cur)
        PAT_READ:
          if (run_phases(tick, tm_read_on, '0) && tail_done(1'b1)) clear_request(PAT_READ);
        PAT_ONE:
          if (run_phases(tick, tm_single_on, '0) && tail_done(1'b0)) clear_request(PAT_ONE);
        PAT_TWO, PAT_FOUR:
          if (run_phases(tick, tm_short_on, tm_short_off) && tail_done(1'b0))
            clear_request(cur);
        PAT_ADDR:
          if (run_phases(tick, tm_short_on, '0)) clear_request(PAT_ADDR);
        PAT_ALARM:
          if (run_phases(tick, tm_alarm_on, tm_alarm_off)) clear_request(PAT_ALARM);
        PAT_HOLD: begin
          buzz = 1'b1;
          if (pend[PAT_HOLD-1] == 0) clear_request(PAT_HOLD);
        end
        default: buzz = 1'b0;
      endcase
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      case (w.mode)
        MODE_POLL:  poll(w.tick);
        MODE_SET:   set_request(w.pattern);
        MODE_CLEAR: clear_request(w.pattern);
        default: ;
      endcase
      r.buzzer_on = buzz;
      r.active_pattern = cur;
      beeps_due.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (beeps_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = beeps_due.pop_front();
      if (got.buzzer_on !== want.buzzer_on) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: buzzer_on expected %0d got %0d", $time, want.buzzer_on, got.buzzer_on);
      end
      if (got.active_pattern !== want.active_pattern) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: active_pattern expected %0d got %0d", $time,
                   want.active_pattern, got.active_pattern);
      end
    endfunction

    function int waiting();
      return beeps_due.size();
    endfunction
  endclass

  beep_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word, with an occasional idle burst first, and hold it until taken
  task automatic send_word(bit [1:0] m, bit [2:0] p, bit t);
    int pause;
    if (idling && $urandom_range(0, 7) == 0) begin
      pause = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= in_word_t'({m, p, t});
    do @(posedge clk); while (in_stall);
    sb.note_word(in_word);
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all timing registers with values from lo to hi
  task automatic load_timing(int lo, int hi);
    for (int k = CFG_READ_ON; k <= CFG_ALARM_OFF; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data <= 12'($urandom_range(hi, lo));
      @(posedge clk);
      sb.set_timing(cfg_index_t'(k), cfg_data);
    end
    cfg_write <= 1'b0;
  endtask

  // Mostly a set followed by a run of polls, plus stray clears and noise
  task automatic run_phase(int n_words);
    int stop_at, r, n;
    bit [2:0] p;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        p = ($urandom_range(0, 9) == 0) ? 3'(PAT_HOLD) : 3'($urandom_range(1, 6));
        send_word(MODE_SET, p, 1'($urandom_range(0, 1)));
        n = $urandom_range(4, 150);
        repeat (n) begin
          if (words_sent >= stop_at) break;
          if ($urandom_range(0, 19) == 0)
            send_word(2'($urandom_range(1, 2)), 3'($urandom_range(1, 7)),
                      1'($urandom_range(0, 1)));
          else
            send_word(MODE_POLL, 3'($urandom_range(0, 7)), $urandom_range(0, 4) != 0);
        end
      end else if (r < 85) begin
        send_word(MODE_CLEAR, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side: check taken words, stall in bursts, and hold off long on request
  initial begin : receiver
    int hold_left;
    bit stall_next;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_word);
      if (choke_req) begin
        choke_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 11);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  initial begin : stimulus
    sb = new();
    idling = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle polls, ignored words, group clearing, every pattern
    send_word(MODE_POLL, PAT_IDLE, 1'b0);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_UNUSED, PAT_HOLD, 1'b1);
    send_word(MODE_SET, PAT_IDLE, 1'b1);
    send_word(MODE_CLEAR, PAT_IDLE, 1'b0);
    send_word(MODE_SET, PAT_HOLD, 1'b0);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_SET, PAT_ALARM, 1'b0);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b0);
    send_word(MODE_SET, PAT_HOLD, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_CLEAR, PAT_HOLD, 1'b0);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_SET, PAT_READ, 1'b0);
    send_word(MODE_SET, PAT_ONE, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_SET, PAT_TWO, 1'b0);
    send_word(MODE_SET, PAT_FOUR, 1'b0);
    send_word(MODE_SET, PAT_ADDR, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b1);
    send_word(MODE_CLEAR, PAT_READ, 1'b1);
    send_word(MODE_POLL, PAT_IDLE, 1'b0);
    send_word(MODE_CLEAR, PAT_ADDR, 1'b0);
    settle();

    load_timing(0, 0);
    run_phase(250);
    settle();

    // Long receiver hold-off fills the block while words keep coming
    load_timing(0, 4);
    choke_req = 1'b1;
    run_phase(250);
    settle();

    load_timing(4095, 4095);
    run_phase(200);
    settle();

    load_timing(0, 15);
    run_phase(250);
    settle();

    // Keep a hold request up under ticking polls, with short beeps on top
    load_timing(0, 3);
    send_word(MODE_SET, PAT_HOLD, 1'b0);
    repeat (200) begin
      if ($urandom_range(0, 39) == 0)
        send_word(MODE_SET, 3'($urandom_range(1, 5)), 1'b1);
      else
        send_word(MODE_POLL, PAT_IDLE, $urandom_range(0, 19) != 0);
    end
    settle();

    load_timing(0, 40);
    run_phase(250);
    settle();

    // Last stretch runs at full rate
    idling = 1'b0;
    load_timing(0, 6);
    run_phase(300);
    settle();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.waiting() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
